FILE: rtl/ssti_pkg.sv
// Shared types and constants for the strict string-to-integer parser.
`default_nettype none
package ssti_pkg;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// target width codes
	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_RADIX  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SIGNED = 2'd2;

	// characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	// one classified character or terminator
	typedef struct packed {
		logic       is_end;
		logic       is_sign;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       dig_ok;
		logic [5:0] dig_val;
	} item_t;

endpackage
`default_nettype wire

FILE: rtl/ssti_if.sv
// Handshake interfaces for the character stream and the result stream.
`default_nettype none
interface ssti_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_mark;
	modport source (output valid, char_byte, end_mark, input ready);
	modport sink (input valid, char_byte, end_mark, output ready);
endinterface

interface ssti_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/ssti_front.sv
// Front end: accepts characters and classifies them for the parse engine.
`default_nettype none
module ssti_front (
	ssti_char_if.sink      chars,
	input  wire logic      q_full,
	output logic           push,
	output ssti_pkg::item_t item
);
	import ssti_pkg::*;

	logic [7:0] c;

	assign c = chars.char_byte;
	assign chars.ready = !q_full;
	assign push = chars.valid && !q_full;

	always_comb begin
		item = '0;
		item.is_end   = chars.end_mark;
		item.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
		item.is_minus = (c == CH_MINUS);
		item.is_zero  = (c == CH_0);
		item.is_x     = (c == CH_LX) || (c == CH_UX);
		priority if (c >= CH_0 && c <= CH_9) begin
			item.dig_ok  = 1'b1;
			item.dig_val = 6'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			item.dig_ok  = 1'b1;
			item.dig_val = 6'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			item.dig_ok  = 1'b1;
			item.dig_val = 6'(c - CH_UA + 8'd10);
		end else begin
			item.dig_ok  = 1'b0;
			item.dig_val = '0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ssti_queue.sv
// Two-entry queue between the front end and the parse engine.
`default_nettype none
module ssti_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ssti_pkg::item_t wr_item,
	input  wire logic            pop,
	output logic                 full,
	output logic                 nonempty,
	output ssti_pkg::item_t      head
);
	import ssti_pkg::*;

	item_t      mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_item;
	end

endmodule
`default_nettype wire

FILE: rtl/ssti_back.sv
// Parse engine: sign/prefix handling, digit accumulation and the final range check.
`default_nettype none
module ssti_back #(
	parameter int ACC_BITS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire ssti_pkg::item_t head,
	output logic                 pop,
	input  wire logic [5:0]      radix,
	input  wire logic [1:0]      width_code,
	input  wire logic            signed_mode,
	ssti_result_if.source        results
);
	import ssti_pkg::*;

	localparam logic [2:0] PH_START        = 3'd0;
	localparam logic [2:0] PH_AFTER_SIGN   = 3'd1;
	localparam logic [2:0] PH_ZERO_PENDING = 3'd2;
	localparam logic [2:0] PH_NEED_DIGIT   = 3'd3;
	localparam logic [2:0] PH_DIGITS       = 3'd4;

	localparam logic [5:0]  RADIX_OCT = 6'd8;
	localparam logic [5:0]  RADIX_DEC = 6'd10;
	localparam logic [5:0]  RADIX_HEX = 6'd16;
	localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;

	logic [2:0]          phase_q, phase_d;
	logic [ACC_BITS-1:0] acc_q, acc_d;
	logic                neg_q, neg_d;
	logic [5:0]          arad_q, arad_d;
	logic [1:0]          err_q, err_d;

	logic                res_valid_q;
	logic [63:0]         value_q;
	logic [1:0]          status_q;

	logic                first_char;
	logic [5:0]          r_first;
	logic [5:0]          r_use;
	logic [ACC_BITS+5:0] prod;
	logic [ACC_BITS+6:0] sum;
	logic                dig_bad;
	logic                ovf;

	logic [1:0]          fin_st;
	logic [63:0]         fin_val;
	logic [63:0]         r64;
	logic [63:0]         vs;
	logic [63:0]         sx;
	logic [63:0]         um;
	logic                u_fit;

	assign pop = head_valid && (!head.is_end || !res_valid_q || results.ready);

	// digit step: one 64x6 product, add and overflow test
	assign first_char = (phase_q == PH_START) || (phase_q == PH_AFTER_SIGN);
	assign r_first = (radix != 6'd0) ? radix : (head.is_zero ? RADIX_OCT : RADIX_DEC);
	assign r_use   = first_char ? r_first : arad_q;
	assign prod    = (ACC_BITS+6)'(acc_q) * (ACC_BITS+6)'(r_use);
	assign sum     = (ACC_BITS+7)'(prod) + (ACC_BITS+7)'(head.dig_val);
	assign ovf     = (sum[ACC_BITS+6:ACC_BITS] != '0);
	assign dig_bad = !head.dig_ok || (head.dig_val >= r_use);

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		arad_d  = arad_q;
		err_d   = err_q;
		if (err_q == ST_OK) begin
			if (phase_q == PH_START && head.is_sign) begin
				neg_d   = head.is_minus;
				phase_d = PH_AFTER_SIGN;
			end else if (first_char && head.is_zero) begin
				arad_d  = r_first;
				phase_d = PH_ZERO_PENDING;
			end else if (phase_q == PH_ZERO_PENDING && head.is_x) begin
				phase_d = PH_NEED_DIGIT;
				if (radix == 6'd0) arad_d = RADIX_HEX;
			end else begin
				// leading zero before this digit leaves the accumulator at zero
				if (first_char) arad_d = r_first;
				phase_d = PH_DIGITS;
				priority if (dig_bad) begin
					err_d = ST_INVALID;
				end else if (ovf) begin
					err_d = ST_RANGE;
				end else begin
					acc_d = sum[ACC_BITS-1:0];
				end
			end
		end
	end

	// terminator: final status and target-width check
	assign r64 = 64'(acc_q);
	assign vs  = neg_q ? (64'd0 - r64) : r64;

	always_comb begin
		unique case (width_code)
			WC_8: begin
				sx    = {{56{vs[7]}}, vs[7:0]};
				um    = {56'd0, vs[7:0]};
				u_fit = (r64[63:8] == '0);
			end
			WC_16: begin
				sx    = {{48{vs[15]}}, vs[15:0]};
				um    = {48'd0, vs[15:0]};
				u_fit = (r64[63:16] == '0);
			end
			WC_32: begin
				sx    = {{32{vs[31]}}, vs[31:0]};
				um    = {32'd0, vs[31:0]};
				u_fit = (r64[63:32] == '0);
			end
			default: begin
				sx    = vs;
				um    = vs;
				u_fit = 1'b1;
			end
		endcase

		fin_val = '0;
		priority if (err_q != ST_OK) begin
			fin_st = err_q;
		end else if (phase_q != PH_DIGITS && phase_q != PH_ZERO_PENDING) begin
			fin_st = ST_INVALID;
		end else if (signed_mode) begin
			if ((neg_q ? (r64 > TOP_BIT) : r64[63]) || (sx != vs)) begin
				fin_st = ST_RANGE;
			end else begin
				fin_st  = ST_OK;
				fin_val = vs;
			end
		end else begin
			if (!u_fit) begin
				fin_st = ST_RANGE;
			end else begin
				fin_st  = ST_OK;
				fin_val = um;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			arad_q      <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && head.is_end) begin
				phase_q     <= PH_START;
				acc_q       <= '0;
				neg_q       <= 1'b0;
				arad_q      <= '0;
				err_q       <= ST_OK;
				res_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					phase_q <= phase_d;
					acc_q   <= acc_d;
					neg_q   <= neg_d;
					arad_q  <= arad_d;
					err_q   <= err_d;
				end
				if (results.ready) res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_end) begin
			value_q  <= fin_val;
			status_q <= fin_st;
		end
	end

	assign results.valid  = res_valid_q;
	assign results.value  = value_q;
	assign results.status = status_q;

endmodule
`default_nettype wire

FILE: rtl/strict_string_to_integer_top.sv
// Strict string-to-integer parser: APB registers, front end, queue and parse engine.
//
// Usage: characters of one numeral arrive on the chars channel, one per
// transaction, and an item with end_mark set closes the numeral. Each
// terminator yields exactly one transaction on the results channel carrying
// value and status (0 ok, 1 invalid syntax, 2 out of range); other items give
// no result. radix, width_code and signed_mode are written over APB while the
// parser is idle.
// Throughput is one item per cycle while no held result blocks a terminator:
// the front end classifies each character and the parse engine performs a
// single 64x6 multiply-add per digit. A terminator is written into the queue,
// and its result is then registered in the output register.
// When the results receiver stalls, the held result waits in the output
// register; characters keep flowing into the two-entry queue and the engine
// keeps consuming them until the next terminator reaches it, then the queue
// fills and chars.ready drops.
// Reset clears the parse state and the queue and sets radix 0 (auto-detect),
// width_code 3 (64 bits) and signed_mode 0.
`default_nettype none
module strict_string_to_integer_top #(
	parameter int ACC_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	ssti_char_if.sink        chars,
	ssti_result_if.source    results
);
	import ssti_pkg::*;

	logic [5:0] radix_q;
	logic [1:0] width_code_q;
	logic       signed_mode_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	logic  q_full;
	logic  q_nonempty;
	logic  push;
	logic  pop;
	item_t f_item;
	item_t q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= 6'd0;
			width_code_q  <= WC_64;
			signed_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RADIX:  radix_q       <= pwdata[5:0];
				REG_WIDTH:  width_code_q  <= pwdata[1:0];
				REG_SIGNED: signed_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RADIX:  prdata = {26'd0, radix_q};
			REG_WIDTH:  prdata = {30'd0, width_code_q};
			REG_SIGNED: prdata = {31'd0, signed_mode_q};
			default:    prdata = '0;
		endcase
	end

	ssti_front u_front (
		.chars  (chars),
		.q_full (q_full),
		.push   (push),
		.item   (f_item)
	);

	ssti_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	ssti_back #(
		.ACC_BITS (ACC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_nonempty),
		.head        (q_head),
		.pop         (pop),
		.radix       (radix_q),
		.width_code  (width_code_q),
		.signed_mode (signed_mode_q),
		.results     (results)
	);

endmodule
`default_nettype wire
